/* rtl/vgm_command_stream_player_core_assert.svh */
// Assertion macros for the command stream player checker.
// Included by the checker file; needs clk and rst_n in scope.
`ifndef VGM_COMMAND_STREAM_PLAYER_CORE_ASSERT_SVH
`define VGM_COMMAND_STREAM_PLAYER_CORE_ASSERT_SVH

// same-cycle implication
`define VGMP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vgmp checker: same-cycle rule violated");

// next-cycle implication
`define VGMP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vgmp checker: next-cycle rule violated");

`endif

/* rtl/vgmp_pkg.sv */
// Shared types and constants for the command stream player.
// No dependencies.
package vgmp_pkg;

  localparam int DATA_W = 8;
  localparam int SPF_W  = 11;
  localparam int WAIT_W = 16;
  localparam int ACT_W  = 2;
  localparam int CFG_IDX_W = 2;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic [DATA_W-1:0] OP_SKIP = 8'h4F;
  localparam logic [DATA_W-1:0] OP_PSG  = 8'h50;
  localparam logic [DATA_W-1:0] OP_WAIT = 8'h61;
  localparam logic [DATA_W-1:0] OP_END  = 8'h66;
  localparam logic [DATA_W-1:0] LATCH_MASK = 8'hE0;
  localparam logic [DATA_W-1:0] LATCH_CH0  = 8'h80;

  localparam logic [SPF_W-1:0] SPF_RESET = 11'd737;
  localparam logic [SPF_W-1:0] SPF_MIN   = 11'd1;

  localparam logic [ACT_W-1:0] ACT_BYTE    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_TICK    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RESTART = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_EFFECT_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_CH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPF         = 2'd2;

  typedef enum logic [2:0] {
    OPC_OTHER,
    OPC_SKIP,
    OPC_PSG,
    OPC_WAIT,
    OPC_END
  } opc_t;

  typedef enum logic [2:0] {
    PH_OPCODE,
    PH_SKIP,
    PH_PSG,
    PH_WLO,
    PH_WHI
  } phase_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [DATA_W-1:0] data_byte;
    logic              last_byte;
    opc_t              opc;
    logic              latch0;
  } cmd_t;

endpackage

/* rtl/vgm_command_stream_player_core.sv */
// Top level of the command stream player: front end, queue, back end.
// Depends on vgmp_pkg, vgmp_front and vgmp_back.
//
// Input channel (in_valid / in_stall): one word per item, either a stream
// byte, a frame tick or a restart. Result channel (out_valid / out_stall):
// exactly one result word per input word, in order.
// Config channel (cfg_valid / cfg_ready): index 0 effect_mode, 1
// target_channel, 2 samples_per_frame; cfg_ready is always high. Write
// config only while no items are in flight.
// An accepted word passes through the queue, and its result is registered.
// Throughput: one word per cycle while out_stall is low; the back end
// retires one queued word per cycle through its single parse/wait update.
// A two-entry queue sits between front and back; in_stall rises only when
// the queue is full, which with words arriving back to back happens when
// out_stall holds the result register. A stalled result holds steady.
// Reset (synchronous, rst_n low) empties the queue and result register,
// clears the parse state and wait, and loads the config defaults.
module vgm_command_stream_player_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vgmp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vgmp_pkg::SPF_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [vgmp_pkg::ACT_W-1:0]      in_action,
  input  logic [vgmp_pkg::DATA_W-1:0]     in_data_byte,
  input  logic                            in_last_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_psg_valid,
  output logic [vgmp_pkg::DATA_W-1:0]     out_psg_byte,
  output logic                            out_wait_active,
  output logic                            out_finished,
  output logic                            out_mute_channel,
  output logic                            out_underrun
);
  import vgmp_pkg::*;

  cmd_t head;
  logic head_valid;
  logic pop;

  vgmp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .pop          (pop),
    .head_valid   (head_valid),
    .head         (head)
  );

  vgmp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .head_valid       (head_valid),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_psg_valid    (out_psg_valid),
    .out_psg_byte     (out_psg_byte),
    .out_wait_active  (out_wait_active),
    .out_finished     (out_finished),
    .out_mute_channel (out_mute_channel),
    .out_underrun     (out_underrun)
  );

endmodule

/* rtl/vgmp_front.sv */
// Front end: accepts input words, classifies opcodes and latch bytes,
// and queues them for the back end. Depends on vgmp_pkg.
module vgmp_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [vgmp_pkg::ACT_W-1:0]   in_action,
  input  logic [vgmp_pkg::DATA_W-1:0]  in_data_byte,
  input  logic                         in_last_byte,
  input  logic                         pop,
  output logic                         head_valid,
  output vgmp_pkg::cmd_t               head
);
  import vgmp_pkg::*;

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push;
  cmd_t              cmd_in;

  function automatic opc_t classify(input logic [DATA_W-1:0] b);
    opc_t c;
    unique case (b)
      OP_SKIP: c = OPC_SKIP;
      OP_PSG:  c = OPC_PSG;
      OP_WAIT: c = OPC_WAIT;
      OP_END:  c = OPC_END;
      default: c = OPC_OTHER;
    endcase
    return c;
  endfunction

  assign in_stall   = (count_r == QCNT_W'(QDEPTH));
  assign push       = in_valid && !in_stall;
  assign head_valid = (count_r != '0);
  assign head       = q_r[rd_ptr_r];

  always_comb begin
    cmd_in.action    = in_action;
    cmd_in.data_byte = in_data_byte;
    cmd_in.last_byte = in_last_byte;
    cmd_in.opc       = classify(in_data_byte);
    cmd_in.latch0    = ((in_data_byte & LATCH_MASK) == LATCH_CH0);
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

/* rtl/vgmp_back.sv */
// Back end: configuration registers, parse state, wait counter and the
// result register. Depends on vgmp_pkg.
module vgmp_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vgmp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vgmp_pkg::SPF_W-1:0]      cfg_data,
  input  logic                            head_valid,
  input  vgmp_pkg::cmd_t                  head,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_psg_valid,
  output logic [vgmp_pkg::DATA_W-1:0]     out_psg_byte,
  output logic                            out_wait_active,
  output logic                            out_finished,
  output logic                            out_mute_channel,
  output logic                            out_underrun
);
  import vgmp_pkg::*;

  logic              effect_r;
  logic [1:0]        tchan_r;
  logic [SPF_W-1:0]  spf_r;

  phase_t            phase_r, phase_nxt;
  logic [WAIT_W-1:0] wait_r, wait_nxt;
  logic [DATA_W-1:0] wlo_r, wlo_nxt;
  logic              ended_r, ended_nxt;
  logic              pnl_r, pnl_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              psg_valid_r, psg_valid_nxt;
  logic [DATA_W-1:0] psg_byte_r, psg_byte_nxt;
  logic              wait_active_r, wait_active_nxt;
  logic              finished_r, finished_nxt;
  logic              mute_r, mute_nxt;
  logic              underrun_r, underrun_nxt;

  logic [WAIT_W-1:0] spf_ext;

  assign cfg_ready = 1'b1;
  assign pop       = head_valid && (!out_valid_r || !out_stall);
  assign spf_ext   = WAIT_W'((spf_r == '0) ? SPF_MIN : spf_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      effect_r <= 1'b0;
      tchan_r  <= 2'd1;
      spf_r    <= SPF_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_EFFECT_MODE: effect_r <= cfg_data[0];
        CFG_TARGET_CH:   tchan_r  <= cfg_data[1:0];
        CFG_SPF:         spf_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_OPCODE;
      wait_r      <= '0;
      wlo_r       <= '0;
      ended_r     <= 1'b0;
      pnl_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      wait_r      <= wait_nxt;
      wlo_r       <= wlo_nxt;
      ended_r     <= ended_nxt;
      pnl_r       <= pnl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      psg_valid_r   <= psg_valid_nxt;
      psg_byte_r    <= psg_byte_nxt;
      wait_active_r <= wait_active_nxt;
      finished_r    <= finished_nxt;
      mute_r        <= mute_nxt;
      underrun_r    <= underrun_nxt;
    end
  end

  always_comb begin
    phase_nxt       = phase_r;
    wait_nxt        = wait_r;
    wlo_nxt         = wlo_r;
    ended_nxt       = ended_r;
    pnl_nxt         = pnl_r;
    psg_valid_nxt   = 1'b0;
    psg_byte_nxt    = '0;
    finished_nxt    = 1'b0;
    mute_nxt        = 1'b0;
    underrun_nxt    = 1'b0;
    out_valid_nxt   = pop ? 1'b1 : (out_valid_r && out_stall);

    if (pop) begin
      unique case (head.action)
        ACT_BYTE: begin
          if (!ended_r && (wait_r < spf_ext)) begin
            unique case (phase_r)
              PH_SKIP: phase_nxt = PH_OPCODE;
              PH_PSG: begin
                psg_valid_nxt = 1'b1;
                psg_byte_nxt  = head.data_byte;
                phase_nxt     = PH_OPCODE;
                if (effect_r) begin
                  if (pnl_r) begin
                    pnl_nxt = 1'b0;
                  end else if (head.latch0) begin
                    pnl_nxt      = 1'b1;
                    psg_byte_nxt = head.data_byte | {1'b0, tchan_r, 5'b0};
                  end
                end
              end
              PH_WLO: begin
                wlo_nxt   = head.data_byte;
                phase_nxt = PH_WHI;
              end
              PH_WHI: begin
                wait_nxt  = {head.data_byte, wlo_r};
                phase_nxt = PH_OPCODE;
              end
              default: begin
                unique case (head.opc)
                  OPC_SKIP: phase_nxt = PH_SKIP;
                  OPC_PSG:  phase_nxt = PH_PSG;
                  OPC_WAIT: phase_nxt = PH_WLO;
                  OPC_END: begin
                    phase_nxt = PH_OPCODE;
                    ended_nxt = 1'b1;
                  end
                  default:  phase_nxt = PH_OPCODE;
                endcase
              end
            endcase
            if (head.last_byte) begin
              ended_nxt = 1'b1;
              phase_nxt = PH_OPCODE;
            end
          end
        end
        ACT_TICK: begin
          if (wait_r > spf_ext) begin
            wait_nxt = wait_r - spf_ext;
          end else begin
            wait_nxt = '0;
            if (ended_r) begin
              finished_nxt = 1'b1;
              if (effect_r) begin
                mute_nxt = 1'b1;
                pnl_nxt  = 1'b0;
              end else begin
                phase_nxt = PH_OPCODE;
                wlo_nxt   = '0;
                ended_nxt = 1'b0;
                pnl_nxt   = 1'b0;
              end
            end else begin
              underrun_nxt = 1'b1;
            end
          end
        end
        ACT_RESTART: begin
          phase_nxt = PH_OPCODE;
          wait_nxt  = '0;
          wlo_nxt   = '0;
          ended_nxt = 1'b0;
          pnl_nxt   = 1'b0;
        end
        default: ;
      endcase
    end

    wait_active_nxt = (wait_nxt >= spf_ext);
  end

  assign out_valid        = out_valid_r;
  assign out_psg_valid    = psg_valid_r;
  assign out_psg_byte     = psg_byte_r;
  assign out_wait_active  = wait_active_r;
  assign out_finished     = finished_r;
  assign out_mute_channel = mute_r;
  assign out_underrun     = underrun_r;

endmodule

/* rtl/vgmp_checker.sv */
// Port-level checker for the command stream player, bound to the top.
// Depends on vgm_command_stream_player_core_assert.svh and vgmp_pkg.
`include "vgm_command_stream_player_core_assert.svh"

module vgmp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_psg_valid,
  input logic [vgmp_pkg::DATA_W-1:0]  out_psg_byte,
  input logic                         out_finished,
  input logic                         out_mute_channel,
  input logic                         out_underrun
);
  import vgmp_pkg::*;

  `VGMP_ASSERT_IMPL(a_mute_needs_finish, out_valid && out_mute_channel, out_finished)
  `VGMP_ASSERT_IMPL(a_psg_not_tick, out_valid && out_psg_valid, !out_finished && !out_underrun)
  `VGMP_ASSERT_IMPL(a_idle_byte_zero, out_valid && !out_psg_valid, out_psg_byte == '0)
  `VGMP_ASSERT_NEXT(a_stall_holds, out_valid && out_stall, out_valid && $stable(out_psg_byte))

endmodule

bind vgm_command_stream_player_core vgmp_checker u_vgmp_checker (.*);
